// ===== hw/rtl/lwac_pkg.sv =====
// Shared types, codes and constants for the lidar window approach controller.
package lwac_pkg;

   localparam int RANGE_BITS = 16;
   localparam int ANGLE_BITS = 16;
   localparam int CMP_BITS   = (ANGLE_BITS > 16) ? ANGLE_BITS + 2 : 18;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [2:0] {
      KIND_SAMPLE = 3'd0,
      KIND_EOS    = 3'd1,
      KIND_TICK   = 3'd2,
      KIND_START  = 3'd3,
      KIND_CANCEL = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_APPROACH   = 3'd0,
      ST_WAITING    = 3'd1,
      ST_REACHED    = 3'd2,
      ST_CANCELED   = 3'd3,
      ST_TO_NOSCAN  = 3'd4,
      ST_TO_NOTGT   = 3'd5,
      ST_TO_APPROACH = 3'd6
   } status_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_STOP_DIST     = 3'd0,
      CSR_MAX_SPEED     = 3'd1,
      CSR_SPEED_GAIN    = 3'd2,
      CSR_TIMEOUT_TICKS = 3'd3,
      CSR_WINDOW_HALF   = 3'd4,
      CSR_ANGLE_START   = 3'd5,
      CSR_ANGLE_STEP    = 3'd6,
      CSR_STALE_TICKS   = 3'd7
   } csr_idx_type;

   localparam logic [15:0] RST_STOP_DIST     = 16'd350;
   localparam logic [11:0] RST_MAX_SPEED     = 12'd150;
   localparam logic [11:0] RST_SPEED_GAIN    = 12'd205;
   localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd0;
   localparam logic [14:0] RST_WINDOW_HALF   = 15'd1820;
   localparam logic [15:0] RST_ANGLE_START   = 16'h8000;
   localparam logic [15:0] RST_ANGLE_STEP    = 16'd182;
   localparam logic [7:0]  RST_STALE_TICKS   = 8'd10;

   typedef struct packed {
      logic [15:0] stop_dist;
      logic [11:0] max_speed;
      logic [11:0] speed_gain;
      logic [15:0] timeout_ticks;
      logic [14:0] window_half;
      logic [15:0] angle_start;
      logic [15:0] angle_step;
      logic [7:0]  stale_ticks;
   } cfg_type;

   // Held scan summary seen by the goal controller
   typedef struct packed {
      logic [RANGE_BITS-1:0] held_min;
      logic                  held_found;
      logic                  have_scan;
      logic [7:0]            age_tick;   // scan age after this tick
   } scan_info_type;

   typedef struct packed {
      status_type   status;
      logic [11:0]  speed_cmd;
      logic [16:0]  remaining_mm;
      logic [15:0]  final_mm;
      logic         done_res;
   } result_type;

   // Signed 16-bit register as an ANGLE_BITS angle
   function automatic logic [ANGLE_BITS-1:0] reg_angle(input logic [15:0] r);
      logic signed [15:0] rs;
      rs = signed'(r);
      return ANGLE_BITS'(rs);
   endfunction

endpackage

// ===== hw/rtl/lidar_window_approach_controller.sv =====
// Top level of the lidar window approach controller: ports, CSRs, input and output registers.
//
// Items enter on the req_ stream: range samples, end-of-scan marks, control ticks, goal
// start and cancel, told apart by req_tuser. Each accepted transfer is captured in an
// input register and processed from there by the scan tracker and the goal controller
// once the output slot is free or being drained; a tick while a goal is active and a
// cancel of an active goal each produce one result transfer on rsp_, other items none.
// Sustained rate is one item per clock while rsp_tready does not stall the output; a
// result passes the input register, then the output register, which drives rsp_tvalid
// and holds it until rsp_tready. The input register keeps taking items as long as it is
// empty or the output slot is free or being drained. rsp_tlast marks a result that ends
// the goal. The user must write the CSRs via csr_we/csr_addr/csr_wdata only while the stream
// is idle, not enforced by the block; a new angle_start takes effect at the next end of scan.
module lidar_window_approach_controller (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] range_mm
   input  logic [3:0]  req_tuser,   // [2:0] kind, [3] range_valid
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [11:0] speed_cmd, [28:12] remaining_mm,
                                    // [44:29] final_mm, [47:45] zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast,   // done_res
   // register write port
   input  logic                               csr_we,
   input  logic [lwac_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [lwac_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   lwac_pkg::cfg_type       cfg_ff, cfg_in;
   lwac_pkg::scan_info_type info;
   lwac_pkg::result_type    res;
   lwac_pkg::result_type    rsp_ff, rsp_in;

   logic        in_valid_ff, in_valid_in;
   logic [2:0]  in_kind_ff, in_kind_in;
   logic [15:0] in_range_ff, in_range_in;
   logic        in_rvalid_ff, in_rvalid_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic advance, proc, res_valid;

   // Output slot is free or its transfer completes this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign proc       = in_valid_ff && advance;

   // CSR writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            lwac_pkg::CSR_STOP_DIST:     cfg_in.stop_dist     = csr_wdata;
            lwac_pkg::CSR_MAX_SPEED:     cfg_in.max_speed     = csr_wdata[11:0];
            lwac_pkg::CSR_SPEED_GAIN:    cfg_in.speed_gain    = csr_wdata[11:0];
            lwac_pkg::CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata;
            lwac_pkg::CSR_WINDOW_HALF:   cfg_in.window_half   = csr_wdata[14:0];
            lwac_pkg::CSR_ANGLE_START:   cfg_in.angle_start   = csr_wdata;
            lwac_pkg::CSR_ANGLE_STEP:    cfg_in.angle_step    = csr_wdata;
            lwac_pkg::CSR_STALE_TICKS:   cfg_in.stale_ticks   = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_dist     <= lwac_pkg::RST_STOP_DIST;
         cfg_ff.max_speed     <= lwac_pkg::RST_MAX_SPEED;
         cfg_ff.speed_gain    <= lwac_pkg::RST_SPEED_GAIN;
         cfg_ff.timeout_ticks <= lwac_pkg::RST_TIMEOUT_TICKS;
         cfg_ff.window_half   <= lwac_pkg::RST_WINDOW_HALF;
         cfg_ff.angle_start   <= lwac_pkg::RST_ANGLE_START;
         cfg_ff.angle_step    <= lwac_pkg::RST_ANGLE_STEP;
         cfg_ff.stale_ticks   <= lwac_pkg::RST_STALE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: loads on every req transfer
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_kind_in   = in_kind_ff;
      in_range_in  = in_range_ff;
      in_rvalid_in = in_rvalid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         if (req_tvalid) begin
            in_kind_in   = req_tuser[2:0];
            in_range_in  = req_tdata;
            in_rvalid_in = req_tuser[3];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      in_kind_ff   <= in_kind_in;
      in_range_ff  <= in_range_in;
      in_rvalid_ff <= in_rvalid_in;
   end

   lwac_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .do_sample   (proc && in_kind_ff == lwac_pkg::KIND_SAMPLE),
      .do_eos      (proc && in_kind_ff == lwac_pkg::KIND_EOS),
      .do_tick     (proc && in_kind_ff == lwac_pkg::KIND_TICK),
      .range_mm    (in_range_ff),
      .range_valid (in_rvalid_ff),
      .cfg         (cfg_ff),
      .info        (info)
   );

   lwac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .proc      (proc),
      .kind      (in_kind_ff),
      .cfg       (cfg_ff),
      .info      (info),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = proc && res_valid;
         if (proc && res_valid) rsp_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.final_mm, rsp_ff.remaining_mm, rsp_ff.speed_cmd};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.done_res;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !proc)
      else $error("item processed while a result is stalled");

   a_final_only_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.final_mm != '0) |-> rsp_ff.done_res)
      else $error("final distance on a non-final result");

   a_done_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.done_res) |->
         (rsp_ff.status != lwac_pkg::ST_APPROACH && rsp_ff.status != lwac_pkg::ST_WAITING))
      else $error("final result with a continuing status");

endmodule

// ===== hw/rtl/lwac_scan.sv =====
// Scan tracker: windowed minimum over a scan, latched at end of scan, scan age.
module lwac_scan (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           do_sample,
   input  logic                           do_eos,
   input  logic                           do_tick,
   input  logic [lwac_pkg::RANGE_BITS-1:0] range_mm,
   input  logic                           range_valid,
   input  lwac_pkg::cfg_type              cfg,
   output lwac_pkg::scan_info_type        info
);

   logic [lwac_pkg::RANGE_BITS-1:0] scan_min_ff, scan_min_in;
   logic                            scan_found_ff, scan_found_in;
   logic [lwac_pkg::ANGLE_BITS-1:0] angle_ff, angle_in;
   logic [lwac_pkg::RANGE_BITS-1:0] held_min_ff, held_min_in;
   logic                            held_found_ff, held_found_in;
   logic                            have_scan_ff, have_scan_in;
   logic [7:0]                      age_ff, age_in;

   logic signed [lwac_pkg::CMP_BITS-1:0] ang_s, half_s;
   logic                                 in_win;
   logic [7:0]                           age_sat;

   assign ang_s  = lwac_pkg::CMP_BITS'(signed'(angle_ff));
   assign half_s = signed'(lwac_pkg::CMP_BITS'(cfg.window_half));
   assign in_win = (ang_s >= -half_s) && (ang_s <= half_s);

   assign age_sat = (age_ff == 8'hFF) ? age_ff : age_ff + 8'd1;

   always_comb begin
      scan_min_in   = scan_min_ff;
      scan_found_in = scan_found_ff;
      angle_in      = angle_ff;
      held_min_in   = held_min_ff;
      held_found_in = held_found_ff;
      have_scan_in  = have_scan_ff;
      age_in        = age_ff;
      if (do_sample) begin
         if (range_valid && in_win) begin
            if (range_mm < scan_min_ff) scan_min_in = range_mm;
            scan_found_in = 1'b1;
         end
         angle_in = angle_ff + lwac_pkg::reg_angle(cfg.angle_step);
      end
      if (do_eos) begin
         held_min_in   = scan_min_ff;
         held_found_in = scan_found_ff;
         have_scan_in  = 1'b1;
         age_in        = '0;
         scan_min_in   = '1;
         scan_found_in = 1'b0;
         angle_in      = lwac_pkg::reg_angle(cfg.angle_start);
      end
      if (do_tick) age_in = age_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_min_ff   <= '1;
         scan_found_ff <= 1'b0;
         angle_ff      <= lwac_pkg::reg_angle(lwac_pkg::RST_ANGLE_START);
         held_min_ff   <= '0;
         held_found_ff <= 1'b0;
         have_scan_ff  <= 1'b0;
         age_ff        <= '0;
      end else begin
         scan_min_ff   <= scan_min_in;
         scan_found_ff <= scan_found_in;
         angle_ff      <= angle_in;
         held_min_ff   <= held_min_in;
         held_found_ff <= held_found_in;
         have_scan_ff  <= have_scan_in;
         age_ff        <= age_in;
      end
   end

   assign info.held_min   = held_min_ff;
   assign info.held_found = held_found_ff;
   assign info.have_scan  = have_scan_ff;
   assign info.age_tick   = age_sat;

endmodule

// ===== hw/rtl/lwac_ctrl.sv =====
// Goal controller: active flag, elapsed ticks and the per-tick decision.
module lwac_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    proc,
   input  logic [2:0]              kind,
   input  lwac_pkg::cfg_type       cfg,
   input  lwac_pkg::scan_info_type info,
   output logic                    res_valid,
   output lwac_pkg::result_type    res
);

   logic        active_ff, active_in;
   logic [15:0] elapsed_ff, elapsed_in;

   logic [15:0]        el_sat;
   logic               expired, stale;
   logic signed [16:0] rem;
   logic [27:0]        prod;
   logic [19:0]        spd_raw;
   logic [11:0]        spd;

   assign el_sat  = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign expired = (cfg.timeout_ticks != '0) && (el_sat > cfg.timeout_ticks);
   assign stale   = !info.have_scan || (info.age_tick > cfg.stale_ticks);
   assign rem     = signed'({1'b0, info.held_min}) - signed'({1'b0, cfg.stop_dist});
   // rem is positive wherever the speed is used
   assign prod    = cfg.speed_gain * rem[15:0];
   assign spd_raw = prod[27:8];
   assign spd     = (spd_raw > 20'(cfg.max_speed)) ? cfg.max_speed : spd_raw[11:0];

   always_comb begin
      active_in        = active_ff;
      elapsed_in       = elapsed_ff;
      res_valid        = 1'b0;
      res.status       = lwac_pkg::ST_WAITING;
      res.speed_cmd    = '0;
      res.remaining_mm = '0;
      res.final_mm     = '0;
      res.done_res     = 1'b0;
      if (proc) begin
         priority if (kind == lwac_pkg::KIND_START) begin
            active_in  = 1'b1;
            elapsed_in = '0;
         end else if (kind == lwac_pkg::KIND_CANCEL && active_ff) begin
            active_in    = 1'b0;
            res_valid    = 1'b1;
            res.status   = lwac_pkg::ST_CANCELED;
            res.done_res = 1'b1;
         end else if (kind == lwac_pkg::KIND_TICK && active_ff) begin
            elapsed_in = el_sat;
            res_valid  = 1'b1;
            priority if (stale) begin
               if (expired) begin
                  active_in    = 1'b0;
                  res.status   = lwac_pkg::ST_TO_NOSCAN;
                  res.done_res = 1'b1;
               end
            end else if (!info.held_found) begin
               if (expired) begin
                  active_in    = 1'b0;
                  res.status   = lwac_pkg::ST_TO_NOTGT;
                  res.done_res = 1'b1;
               end
            end else if (rem <= 17'sd0) begin
               active_in        = 1'b0;
               res.status       = lwac_pkg::ST_REACHED;
               res.remaining_mm = rem;
               res.final_mm     = info.held_min;
               res.done_res     = 1'b1;
            end else if (expired) begin
               active_in        = 1'b0;
               res.status       = lwac_pkg::ST_TO_APPROACH;
               res.remaining_mm = rem;
               res.final_mm     = info.held_min;
               res.done_res     = 1'b1;
            end else begin
               res.status       = lwac_pkg::ST_APPROACH;
               res.speed_cmd    = spd;
               res.remaining_mm = rem;
            end
         end else begin
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         elapsed_ff <= '0;
      end else begin
         active_ff  <= active_in;
         elapsed_ff <= elapsed_in;
      end
   end

   a_done_ends_goal: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.done_res) |=> !active_ff)
      else $error("goal still active after a final result");

   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      (proc && kind == lwac_pkg::KIND_START) |=> (active_ff && elapsed_ff == '0))
      else $error("start did not arm the goal");

   a_speed_only_approach: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.speed_cmd != '0) |-> (res.status == lwac_pkg::ST_APPROACH))
      else $error("nonzero speed outside approaching");

   a_result_needs_goal: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> active_ff)
      else $error("result while no goal active");

endmodule

// ===== verif/lwac_checker.sv =====
// Scoreboard for the lidar window approach controller: predicts results and compares them.
module lwac_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // [15:0] range_mm
   input  logic [3:0]                         req_tuser,   // [2:0] kind, [3] range_valid
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [47:0]                        rsp_tdata,   // [11:0] speed, [28:12] remaining,
                                                           // [44:29] final
   input  logic [2:0]                         rsp_tuser,   // [2:0] status
   input  logic                               rsp_tlast,   // done_res
   input  logic                               csr_we,
   input  logic [lwac_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [lwac_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                 fail_count,
   output int                                 open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   lwac_pkg::cfg_type               cfg;
   logic [lwac_pkg::RANGE_BITS-1:0] beam_min, latched_min;
   logic                            beam_hit, latched_hit, scan_ready, goal_live;
   logic [lwac_pkg::ANGLE_BITS-1:0] beam_angle;
   logic [7:0]                      scan_old;
   logic [15:0]                     goal_ticks;
   lwac_pkg::result_type            due_q[$];
   int                              misses = 0;
   int                              backlog = 0;

   assign fail_count = misses;
   assign open_count = backlog;

   function automatic logic [lwac_pkg::ANGLE_BITS-1:0] to_angle(input logic [15:0] r);
      return lwac_pkg::ANGLE_BITS'(signed'(r));
   endfunction

   function automatic bit in_beam(input logic [lwac_pkg::ANGLE_BITS-1:0] a);
      int sa;
      int h;
      sa = int'(signed'(a));
      h  = int'(cfg.window_half);
      return (sa >= -h) && (sa <= h);
   endfunction

   function automatic lwac_pkg::result_type make_rsp(input lwac_pkg::status_type st,
                                                     input logic [11:0] spd,
                                                     input int rem, input logic [15:0] fin,
                                                     input logic done);
      lwac_pkg::result_type r;
      if (rem > 65535) rem = 65535;
      if (rem < -65535) rem = -65535;
      r.status       = st;
      r.speed_cmd    = spd;
      r.remaining_mm = 17'(rem);
      r.final_mm     = fin;
      r.done_res     = done;
      return r;
   endfunction

   task automatic flag(input string what, input longint got, input longint want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      misses++;
   endtask

   task automatic apply_item(input logic [2:0] kind, input logic [15:0] rng, input logic ok);
      bit     expired;
      int     rem;
      longint spd;
      case (kind)
         lwac_pkg::KIND_SAMPLE: begin
            if (ok && in_beam(beam_angle)) begin
               if (rng < beam_min) beam_min = rng;
               beam_hit = 1'b1;
            end
            beam_angle = beam_angle + to_angle(cfg.angle_step);
         end
         lwac_pkg::KIND_EOS: begin
            latched_min = beam_min;
            latched_hit = beam_hit;
            scan_ready  = 1'b1;
            scan_old    = '0;
            beam_min    = '1;
            beam_hit    = 1'b0;
            beam_angle  = to_angle(cfg.angle_start);
         end
         lwac_pkg::KIND_START: begin
            goal_live  = 1'b1;
            goal_ticks = '0;
         end
         lwac_pkg::KIND_CANCEL: begin
            if (goal_live) begin
               goal_live = 1'b0;
               due_q.push_back(make_rsp(lwac_pkg::ST_CANCELED, '0, 0, '0, 1'b1));
            end
         end
         lwac_pkg::KIND_TICK: begin
            if (scan_old != 8'hFF) scan_old++;
            if (goal_live) begin
               if (goal_ticks != 16'hFFFF) goal_ticks++;
               expired = (cfg.timeout_ticks != 0) && (goal_ticks > cfg.timeout_ticks);
               if (!scan_ready || scan_old > cfg.stale_ticks) begin
                  if (expired) begin
                     goal_live = 1'b0;
                     due_q.push_back(make_rsp(lwac_pkg::ST_TO_NOSCAN, '0, 0, '0, 1'b1));
                  end else begin
                     due_q.push_back(make_rsp(lwac_pkg::ST_WAITING, '0, 0, '0, 1'b0));
                  end
               end else if (!latched_hit) begin
                  if (expired) begin
                     goal_live = 1'b0;
                     due_q.push_back(make_rsp(lwac_pkg::ST_TO_NOTGT, '0, 0, '0, 1'b1));
                  end else begin
                     due_q.push_back(make_rsp(lwac_pkg::ST_WAITING, '0, 0, '0, 1'b0));
                  end
               end else begin
                  rem = int'(latched_min) - int'(cfg.stop_dist);
                  if (rem <= 0) begin
                     goal_live = 1'b0;
                     due_q.push_back(make_rsp(lwac_pkg::ST_REACHED, '0, rem, latched_min,
                                              1'b1));
                  end else if (expired) begin
                     goal_live = 1'b0;
                     due_q.push_back(make_rsp(lwac_pkg::ST_TO_APPROACH, '0, rem, latched_min,
                                              1'b1));
                  end else begin
                     // Q4.8 gain: drop the fraction, then clamp
                     spd = (longint'(cfg.speed_gain) * longint'(rem)) >>> 8;
                     if (spd > longint'(cfg.max_speed)) spd = longint'(cfg.max_speed);
                     due_q.push_back(make_rsp(lwac_pkg::ST_APPROACH, 12'(spd), rem, '0,
                                              1'b0));
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      lwac_pkg::result_type w;
      if (reset) begin
         cfg.stop_dist     = lwac_pkg::RST_STOP_DIST;
         cfg.max_speed     = lwac_pkg::RST_MAX_SPEED;
         cfg.speed_gain    = lwac_pkg::RST_SPEED_GAIN;
         cfg.timeout_ticks = lwac_pkg::RST_TIMEOUT_TICKS;
         cfg.window_half   = lwac_pkg::RST_WINDOW_HALF;
         cfg.angle_start   = lwac_pkg::RST_ANGLE_START;
         cfg.angle_step    = lwac_pkg::RST_ANGLE_STEP;
         cfg.stale_ticks   = lwac_pkg::RST_STALE_TICKS;
         beam_min    = '1;
         beam_hit    = 1'b0;
         beam_angle  = to_angle(lwac_pkg::RST_ANGLE_START);
         latched_min = '0;
         latched_hit = 1'b0;
         scan_ready  = 1'b0;
         scan_old    = '0;
         goal_ticks  = '0;
         goal_live   = 1'b0;
         due_q.delete();
         backlog <= 0;
      end else begin
         if (csr_we) begin
            case (lwac_pkg::csr_idx_type'(csr_addr))
               lwac_pkg::CSR_STOP_DIST:     cfg.stop_dist     = csr_wdata;
               lwac_pkg::CSR_MAX_SPEED:     cfg.max_speed     = csr_wdata[11:0];
               lwac_pkg::CSR_SPEED_GAIN:    cfg.speed_gain    = csr_wdata[11:0];
               lwac_pkg::CSR_TIMEOUT_TICKS: cfg.timeout_ticks = csr_wdata;
               lwac_pkg::CSR_WINDOW_HALF:   cfg.window_half   = csr_wdata[14:0];
               lwac_pkg::CSR_ANGLE_START:   cfg.angle_start   = csr_wdata;
               lwac_pkg::CSR_ANGLE_STEP:    cfg.angle_step    = csr_wdata;
               lwac_pkg::CSR_STALE_TICKS:   cfg.stale_ticks   = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_q.size() == 0) begin
               flag("result with nothing pending, status", rsp_tuser, -1);
            end else begin
               w = due_q.pop_front();
               if (rsp_tuser != w.status) flag("status", rsp_tuser, w.status);
               if (rsp_tdata[11:0] != w.speed_cmd)
                  flag("speed_cmd", rsp_tdata[11:0], w.speed_cmd);
               if (rsp_tdata[28:12] != w.remaining_mm)
                  flag("remaining_mm", signed'(rsp_tdata[28:12]), signed'(w.remaining_mm));
               if (rsp_tdata[44:29] != w.final_mm)
                  flag("final_mm", rsp_tdata[44:29], w.final_mm);
               if (rsp_tlast != w.done_res) flag("done_res", rsp_tlast, w.done_res);
            end
         end
         if (req_tvalid && req_tready)
            apply_item(req_tuser[2:0], req_tdata, req_tuser[3]);
         backlog <= due_q.size();
      end
   end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the lidar window approach controller: stimulus, stalls and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no transfer on either channel
   localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, fills the block
   localparam int PHASE_ITEMS     = 310;
   localparam int SETTLE_CYCLES   = 6;     // covers the two-stage pipeline with margin

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [15:0]                        req_tdata = '0;    // [15:0] range_mm
   logic [3:0]                         req_tuser = '0;    // [2:0] kind, [3] range_valid
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [47:0]                        rsp_tdata;         // [11:0] speed, [28:12] remaining,
                                                          // [44:29] final
   logic [2:0]                         rsp_tuser;         // [2:0] status
   logic                               rsp_tlast;         // done_res
   logic                               csr_we = 1'b0;
   logic [lwac_pkg::CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [lwac_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   int fail_count;
   int open_count;

   // idle odds in percent, per side
   int send_idle_pct = 25;
   int recv_idle_pct = 55;
   int items_sent    = 0;
   int cur_stop      = 350;   // stop distance in force, steers range choice
   bit hold_arm      = 1'b0;  // next goal start triggers the long stall
   bit hold_req      = 1'b0;

   lidar_window_approach_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   lwac_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // One request transfer; random gaps before it, returns at the accepting edge.
   task automatic put_item(input logic [2:0] kind, input logic [15:0] rng, input logic ok);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rng;
      req_tuser  <= {ok, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Wait until every pending result has come out and the pipeline is empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input lwac_pkg::csr_idx_type idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic write_cfg(input logic [15:0] stop, input logic [15:0] vmax,
                            input logic [15:0] gain, input logic [15:0] tmo,
                            input logic [15:0] win, input logic [15:0] ang0,
                            input logic [15:0] angd, input logic [15:0] stale);
      settle();
      put_reg(lwac_pkg::CSR_STOP_DIST, stop);
      put_reg(lwac_pkg::CSR_MAX_SPEED, vmax);
      put_reg(lwac_pkg::CSR_SPEED_GAIN, gain);
      put_reg(lwac_pkg::CSR_TIMEOUT_TICKS, tmo);
      put_reg(lwac_pkg::CSR_WINDOW_HALF, win);
      put_reg(lwac_pkg::CSR_ANGLE_START, ang0);
      put_reg(lwac_pkg::CSR_ANGLE_STEP, angd);
      put_reg(lwac_pkg::CSR_STALE_TICKS, stale);
      csr_we   <= 1'b0;
      cur_stop = stop;
   endtask

   // Scan centered near angle zero so the window sees some of it.
   task automatic random_config();
      int step;
      int win;
      int ang0;
      int tmo;
      step = $urandom_range(1, 3000);
      win  = $urandom_range(step / 2, step * 4);
      if (win > 32767) win = 32767;
      ang0 = -step * int'($urandom_range(2, 8));
      if ($urandom_range(1) == 1) begin
         step = -step;
         ang0 = -ang0;
      end
      tmo = ($urandom_range(99) < 40) ? 0 : $urandom_range(1, 30);
      write_cfg(16'($urandom_range(0, 2500)), 16'($urandom_range(0, 4095)),
                16'($urandom_range(0, 4095)), 16'(tmo), 16'(win), 16'(ang0),
                16'(step), 16'($urandom_range(0, 12)));
   endtask

   // Mostly ranges around the stop distance, some anywhere in 16 bits.
   function automatic logic [15:0] pick_range();
      int hi;
      hi = cur_stop + 1500;
      if (hi > 65535) hi = 65535;
      if ($urandom_range(99) < 15) return 16'($urandom);
      return 16'($urandom_range(0, hi));
   endfunction

   task automatic run_scan();
      int n;
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
         // control ticks keep arriving while a scan is in progress
         if ($urandom_range(99) < 12)
            put_item(lwac_pkg::KIND_TICK, 16'($urandom), 1'($urandom));
         put_item(lwac_pkg::KIND_SAMPLE, pick_range(), $urandom_range(99) < 85);
      end
      put_item(lwac_pkg::KIND_EOS, 16'($urandom), 1'($urandom));
   endtask

   task automatic run_episode();
      int scans;
      int ticks;
      put_item(lwac_pkg::KIND_START, 16'($urandom), 1'($urandom));
      if (hold_arm) begin
         hold_arm = 1'b0;
         hold_req = 1'b1;
      end
      scans = $urandom_range(1, 4);
      for (int s = 0; s < scans; s++) begin
         if ($urandom_range(99) >= 10) run_scan();   // else let the scan go stale
         ticks = $urandom_range(1, 6);
         for (int t = 0; t < ticks; t++)
            put_item(lwac_pkg::KIND_TICK, 16'($urandom), 1'($urandom));
      end
      if ($urandom_range(99) < 25)
         put_item(lwac_pkg::KIND_CANCEL, 16'($urandom), 1'($urandom));
   endtask

   task automatic run_phase(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 85) begin
            run_episode();
         end else begin
            // noise: any kind, unused codes included
            repeat ($urandom_range(1, 3))
               put_item(3'($urandom_range(0, 7)), 16'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings: idle items, unused codes, waiting and cancel.
      put_item(lwac_pkg::KIND_CANCEL, 16'h0000, 1'b0);   // no goal: ignored
      put_item(lwac_pkg::KIND_TICK, 16'hFFFF, 1'b1);     // no goal: no result
      for (int k = int'(lwac_pkg::KIND_CANCEL) + 1; k < 8; k++)
         put_item(3'(k), 16'hA5A5, 1'b1);
      put_item(lwac_pkg::KIND_START, 16'h0000, 1'b0);
      put_item(lwac_pkg::KIND_TICK, 16'h0000, 1'b0);     // no scan yet: waiting
      put_item(lwac_pkg::KIND_SAMPLE, 16'd100, 1'b1);    // far outside the window
      put_item(lwac_pkg::KIND_EOS, 16'h0000, 1'b0);
      put_item(lwac_pkg::KIND_TICK, 16'h0000, 1'b0);     // scan without target: waiting
      put_item(lwac_pkg::KIND_CANCEL, 16'h0000, 1'b0);   // canceled

      // Every sample at angle zero, timeout shorter than staleness.
      write_cfg(16'd350, 16'd4095, 16'd4095, 16'd1, 16'd0, 16'd0, 16'd0, 16'd2);
      put_item(lwac_pkg::KIND_EOS, 16'h0000, 1'b0);      // picks up the new start angle
      put_item(lwac_pkg::KIND_START, 16'h0000, 1'b0);
      put_item(lwac_pkg::KIND_SAMPLE, 16'd1000, 1'b1);
      put_item(lwac_pkg::KIND_SAMPLE, 16'hFFFF, 1'b1);
      put_item(lwac_pkg::KIND_SAMPLE, 16'h0000, 1'b0);   // invalid range is skipped
      put_item(lwac_pkg::KIND_EOS, 16'h0000, 1'b0);
      put_item(lwac_pkg::KIND_TICK, 16'h0000, 1'b0);     // approaching, speed clamped
      put_item(lwac_pkg::KIND_TICK, 16'h0000, 1'b0);     // timeout while approaching
      put_item(lwac_pkg::KIND_START, 16'h0000, 1'b0);
      put_item(lwac_pkg::KIND_TICK, 16'h0000, 1'b0);     // stale scan: waiting
      put_item(lwac_pkg::KIND_TICK, 16'h0000, 1'b0);     // timeout without scan
      put_item(lwac_pkg::KIND_START, 16'h0000, 1'b0);
      put_item(lwac_pkg::KIND_EOS, 16'h0000, 1'b0);      // empty scan
      put_item(lwac_pkg::KIND_TICK, 16'h0000, 1'b0);     // no target: waiting
      put_item(lwac_pkg::KIND_TICK, 16'h0000, 1'b0);     // timeout without target
      put_item(lwac_pkg::KIND_START, 16'h0000, 1'b0);
      put_item(lwac_pkg::KIND_SAMPLE, 16'd350, 1'b1);    // exactly at the stop distance
      put_item(lwac_pkg::KIND_EOS, 16'h0000, 1'b0);
      put_item(lwac_pkg::KIND_TICK, 16'h0000, 1'b0);     // reached

      // Random phases; the long result stall comes with the first goal.
      random_config();
      hold_arm = 1'b1;
      run_phase(PHASE_ITEMS);

      // Upper extremes of every register.
      write_cfg(16'hFFFF, 16'd4095, 16'd4095, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                16'd255);
      run_phase(PHASE_ITEMS);

      send_idle_pct = 55;
      recv_idle_pct = 25;
      // Lower extremes of every register.
      write_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_phase(PHASE_ITEMS);
      random_config();
      run_phase(PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_config();
      run_phase(PHASE_ITEMS);
      random_config();
      run_phase(PHASE_ITEMS);

      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
